[hdl/int_to_decimal_ascii_unit_macros.svh]
// Assertion macros shared by the int_to_decimal_ascii_unit RTL.
`ifndef INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Plain property, clocked on clk_i, off while rst_ni is low.
`define I2DA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define I2DA_ASSERT_IMP(label, ante, cons, msg) \
  `I2DA_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define I2DA_ASSERT_NXT(label, ante, cons, msg) \
  `I2DA_ASSERT(label, (ante) |=> (cons), msg)

`endif

[hdl/i2da_pkg.sv]
// Shared constants and types of the integer to decimal ASCII unit.
package i2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int DD_W       = BCD_W + VALUE_W;
  localparam int DD_STAGES  = 4;
  localparam int DD_STEPS   = VALUE_W / DD_STAGES;
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT   = 4'd9;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic    neg;
    digits_t digits;
  } num_t;

endpackage

[hdl/i2da_bcd_pipe.sv]
// Pipelined binary to BCD conversion (shift and add-3) of the magnitude.
`include "int_to_decimal_ascii_unit_macros.svh"

module i2da_bcd_pipe import i2da_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output num_t               out_num_o
);

  // 8 shift/add-3 iterations per stage
  function automatic logic [DD_W-1:0] dd_steps(input logic [DD_W-1:0] w);
    logic [DD_W-1:0] t;
    t = w;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (t[VALUE_W + DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
          t[VALUE_W + DIGIT_W*d +: DIGIT_W] = t[VALUE_W + DIGIT_W*d +: DIGIT_W] + 4'd3;
        end
      end
      t = t << 1;
    end
    return t;
  endfunction

  function automatic logic all_decimal(input digits_t dg);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (dg[d] > MAX_DIGIT) ok = 1'b0;
    end
    return ok;
  endfunction

  logic [DD_STAGES:0] v_q;
  logic [DD_STAGES:0] en;
  logic [DD_STAGES:0] neg_q;
  logic [DD_W-1:0]    w_q [DD_STAGES+1];
  logic [VALUE_W-1:0] mag;

  assign mag = in_value_i[VALUE_W-1] ? (~in_value_i + VALUE_W'(1)) : in_value_i;

  // a stage loads when empty or when the one after it moves
  assign en[DD_STAGES] = !v_q[DD_STAGES] || !out_stall_i;
  for (genvar k = 0; k < DD_STAGES; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign in_stall_o = !en[0];

  // stage 0: sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg_q[0] <= in_value_i[VALUE_W-1];
      w_q[0]   <= {{BCD_W{1'b0}}, mag};
    end
  end

  for (genvar k = 1; k <= DD_STAGES; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        neg_q[k] <= neg_q[k-1];
        w_q[k]   <= dd_steps(w_q[k-1]);
      end
    end
  end

  assign out_valid_o      = v_q[DD_STAGES];
  assign out_num_o.neg    = neg_q[DD_STAGES];
  assign out_num_o.digits = w_q[DD_STAGES][DD_W-1 -: BCD_W];

  `I2DA_ASSERT_IMP(a_bcd_cleared, v_q[0], w_q[0][DD_W-1 -: BCD_W] == '0, "stage 0 BCD not clear")
  `I2DA_ASSERT_IMP(a_digits_dec, out_valid_o, all_decimal(out_num_o.digits), "BCD digit above 9")
  `I2DA_ASSERT_NXT(a_stage0_hold, v_q[0] && !en[1], v_q[0], "stage 0 item dropped")

endmodule

[hdl/i2da_emit.sv]
// Character serializer: turns one BCD number into ASCII characters.
`include "int_to_decimal_ascii_unit_macros.svh"

module i2da_emit import i2da_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  num_t              in_num_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o
);

  logic              valid_q, valid_d;
  logic              busy_q, busy_d;
  logic              neg_q, neg_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  digits_t           dig_q, dig_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;

  logic              out_free;
  logic              finishing;
  logic              load;
  logic [IDX_W-1:0]  top_idx;
  logic              char_ok;

  assign out_free  = !valid_q || !out_stall_i;
  assign finishing = busy_q && out_free && !neg_q && (idx_q == '0);
  assign load      = in_valid_i && (!busy_q || finishing);
  assign in_stall_o = busy_q && !finishing;

  // most significant nonzero digit; zero gives a single digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (in_num_i.digits[d] != '0) top_idx = IDX_W'(d);
    end
  end

  always_comb begin
    valid_d = valid_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    dig_d   = dig_q;
    char_d  = char_q;
    last_d  = last_q;
    if (busy_q && out_free) begin
      valid_d = 1'b1;
      if (neg_q) begin
        char_d = ASCII_MINUS;
        last_d = 1'b0;
        neg_d  = 1'b0;
      end else begin
        char_d = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_q[idx_q]};
        last_d = (idx_q == '0);
        if (idx_q == '0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
    end else if (out_free) begin
      valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      neg_d  = in_num_i.neg;
      idx_d  = top_idx;
      dig_d  = in_num_i.digits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
      neg_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      busy_q  <= busy_d;
      neg_q   <= neg_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  assign char_ok = (char_q == ASCII_MINUS) || ((char_q >= ASCII_ZERO) && (char_q <= ASCII_NINE));

  `I2DA_ASSERT_IMP(a_char_legal, valid_q, char_ok, "illegal character")
  `I2DA_ASSERT_IMP(a_minus_not_last, valid_q && (char_q == ASCII_MINUS), !last_q, "minus marked last")
  `I2DA_ASSERT_IMP(a_idx_range, busy_q, idx_q <= IDX_W'(NUM_DIGITS - 1), "digit index out of range")

endmodule

[hdl/int_to_decimal_ascii_unit.sv]
// Top level of the signed 32-bit integer to decimal ASCII text unit.
//
// Input channel: value_i (signed 32 bit) with valid_i / stall_o. One transfer
// takes one integer.
// Output channel: character_o and last_o with valid_o / stall_i. Each integer
// gives its decimal text, most significant character first, no leading
// zeros, a leading '-' when negative; "0" for zero. last_o marks the final
// character of each number.
// Path: when the serializer is free, the first character goes from the input
// transfer through the capture stage, four BCD stages, one serializer load
// and one output register.
// Throughput: one character per cycle while stall_i is low; an integer
// gives 1 to 11 characters; the one-character output port sets that rate.
// The BCD pipeline accepts an integer every cycle while stall_o is low and
// buffers up to five while the serializer is busy.
// Reset: asynchronous, active low; clears all valid and busy flags, no
// transfer is in flight afterwards.
// Stall: while stall_i is high the shown character holds; the pipeline
// backs up stage by stage and then raises stall_o. Nothing is lost.

module int_to_decimal_ascii_unit import i2da_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [CHAR_W-1:0]  character_o,
  output logic               last_o
);

  // BCD pipeline to serializer
  logic pipe_valid;
  logic pipe_stall;
  num_t pipe_num;

  i2da_bcd_pipe u_bcd_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_stall_o  (stall_o),
    .in_value_i  (value_i),
    .out_valid_o (pipe_valid),
    .out_stall_i (pipe_stall),
    .out_num_o   (pipe_num)
  );

  // one character per output transfer
  i2da_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pipe_valid),
    .in_stall_o  (pipe_stall),
    .in_num_i    (pipe_num),
    .out_valid_o (valid_o),
    .out_stall_i (stall_i),
    .out_char_o  (character_o),
    .out_last_o  (last_o)
  );

endmodule
